### hdl/tga_rle_pixel_decoder_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the run-length pixel decoder
// Clocked property checks with and without the reset guard.
// ---------------------------------------------------------------------------
`ifndef TGA_RLE_PIXEL_DECODER_CORE_ASSERT_SVH
`define TGA_RLE_PIXEL_DECODER_CORE_ASSERT_SVH

// check a property while out of reset
`define TGARLE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property at every edge, reset included
`define TGARLE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/tgarle_pkg.sv
// ---------------------------------------------------------------------------
// tgarle_pkg
// Types and constants shared by the run-length pixel decoder modules.
// ---------------------------------------------------------------------------
package tgarle_pkg;

    localparam int MAX_PIXEL_BYTES = 4;
    localparam int PALETTE_DEPTH   = 256;
    localparam int POS_W           = (MAX_PIXEL_BYTES > 2) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int PAL_AW          = $clog2(PALETTE_DEPTH);
    localparam int TOKQ_DEPTH      = 4;
    localparam int TOKQ_AW         = $clog2(TOKQ_DEPTH);
    localparam int OUT_DEPTH       = 4;
    localparam int OUT_AW          = $clog2(OUT_DEPTH);

    localparam logic [7:0]  HDR_COUNT_MASK = 8'h7F;
    localparam logic [7:0]  HDR_REPEAT_BIT = 8'h80;
    localparam logic [31:0] INDEX_MASK     = 32'h00FF_FFFF;

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_PALETTE = 2'd1,
        CMD_DATA    = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        REG_IN_BYTES     = 3'd0,
        REG_OUT_BYTES    = 3'd1,
        REG_IMAGE_PIXELS = 3'd2,
        REG_COMPRESSED   = 3'd3,
        REG_COLOR_MAPPED = 3'd4,
        REG_PAL_LENGTH   = 3'd5
    } reg_idx_t;

    typedef enum logic {
        TOK_PALETTE = 1'b0,
        TOK_PIXEL   = 1'b1
    } tok_kind_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  data_byte;
        logic [7:0]  palette_slot;
        logic [31:0] palette_word;
    } item_t;

    typedef struct packed {
        logic [31:0] pixel_value;
        logic [7:0]  run_length;
        logic        last_of_image;
        logic        status;
    } result_t;

    typedef struct packed {
        logic [2:0]  input_pixel_bytes;
        logic [2:0]  output_pixel_bytes;
        logic [31:0] image_pixels;
        logic        compressed_mode;
        logic        color_mapped_mode;
        logic [8:0]  palette_length;
    } cfg_t;

    typedef struct packed {
        tok_kind_t   kind;
        logic [31:0] value;
        logic [7:0]  slot;
        logic [7:0]  run;
        logic        last;
    } tok_t;

endpackage

### hdl/tga_rle_pixel_decoder_core.sv
// ---------------------------------------------------------------------------
// tga_rle_pixel_decoder_core
// Run-length pixel decoder with palette lookup, queue interfaces both sides.
// ---------------------------------------------------------------------------
// Takes one request per clock while full is low: a start, a palette write or
// one stream byte. The parser handles each request in the cycle it is
// accepted, so a byte stream goes in at one byte per clock unless full stalls
// it; a run's last pixel byte passes the request queue, palette read and result queue.
// The palette is a single-port 256 x 32 memory, written and read in request
// order. Read a palette slot only after writing it. Write the registers only
// while no request is in flight.
// ---------------------------------------------------------------------------
module tga_rle_pixel_decoder_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  tgarle_pkg::item_t   item,
    input  logic                pop,
    output logic                empty,
    output tgarle_pkg::result_t result,
    input  logic                wr_en,
    input  logic [2:0]          wr_index,
    input  logic [31:0]         wr_data
);
    import tgarle_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic accept;
    logic tok_push;
    tok_t tok_in;
    tok_t tok_out;
    logic tok_empty;
    logic tok_pop;

    assign accept = push && !full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx_t'(wr_index))
                REG_IN_BYTES:     cfg_next.input_pixel_bytes  = wr_data[2:0];
                REG_OUT_BYTES:    cfg_next.output_pixel_bytes = wr_data[2:0];
                REG_IMAGE_PIXELS: cfg_next.image_pixels       = wr_data;
                REG_COMPRESSED:   cfg_next.compressed_mode    = wr_data[0];
                REG_COLOR_MAPPED: cfg_next.color_mapped_mode  = wr_data[0];
                REG_PAL_LENGTH:   cfg_next.palette_length     = wr_data[8:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_pixel_bytes  <= 3'd1;
            cfg_reg.output_pixel_bytes <= 3'd1;
            cfg_reg.image_pixels       <= 32'd1;
            cfg_reg.compressed_mode    <= 1'b0;
            cfg_reg.color_mapped_mode  <= 1'b0;
            cfg_reg.palette_length     <= 9'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tgarle_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .accept   (accept),
        .item     (item),
        .tok_push (tok_push),
        .tok      (tok_in)
    );

    tgarle_tokq u_tokq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (tok_push),
        .tok_in  (tok_in),
        .full    (full),
        .pop     (tok_pop),
        .tok_out (tok_out),
        .empty   (tok_empty)
    );

    tgarle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .tok_empty (tok_empty),
        .tok       (tok_out),
        .tok_pop   (tok_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

### hdl/tgarle_front.sv
// ---------------------------------------------------------------------------
// tgarle_front
// Packet parser: tracks headers, gathers pixel bytes and clamps runs.
// ---------------------------------------------------------------------------
module tgarle_front (
    input  logic               clk,
    input  logic               rst_n,
    input  tgarle_pkg::cfg_t   cfg,
    input  logic               accept,
    input  tgarle_pkg::item_t  item,
    output logic               tok_push,
    output tgarle_pkg::tok_t   tok
);
    import tgarle_pkg::*;

    logic [31:0]      done_reg,   done_next;
    logic [7:0]       left_reg,   left_next;
    logic             repeat_reg, repeat_next;
    logic [POS_W-1:0] pos_reg,    pos_next;
    logic [31:0]      gather_reg, gather_next;

    logic [32:0] rem;
    logic        image_done;
    logic        rem_small;
    logic [3:0]  n_eff;
    logic        last_byte;
    logic [31:0] gather_new;
    logic [7:0]  run_raw;
    logic [7:0]  run_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= '0;
            left_reg   <= '0;
            repeat_reg <= 1'b0;
            pos_reg    <= '0;
            gather_reg <= '0;
        end
        else
        begin
            done_reg   <= done_next;
            left_reg   <= left_next;
            repeat_reg <= repeat_next;
            pos_reg    <= pos_next;
            gather_reg <= gather_next;
        end
    end

    always_comb
    begin
        rem        = {1'b0, cfg.image_pixels} - {1'b0, done_reg};
        image_done = rem[32] || (rem[31:0] == 32'd0);
        rem_small  = (rem[31:8] == 24'd0);

        if (cfg.input_pixel_bytes == 3'd0)
            n_eff = 4'd1;
        else if (4'(cfg.input_pixel_bytes) > 4'(MAX_PIXEL_BYTES))
            n_eff = 4'(MAX_PIXEL_BYTES);
        else
            n_eff = 4'(cfg.input_pixel_bytes);
        last_byte = (4'(pos_reg) + 4'd1) >= n_eff;

        if (4'(pos_reg) < 4'd4)
            gather_new = gather_reg | ({24'd0, item.data_byte} << {pos_reg[1:0], 3'b000});
        else
            gather_new = gather_reg;

        run_raw = (cfg.compressed_mode && repeat_reg) ? left_reg : 8'd1;
        run_c   = (rem_small && (run_raw > rem[7:0])) ? rem[7:0] : run_raw;
    end

    always_comb
    begin
        done_next   = done_reg;
        left_next   = left_reg;
        repeat_next = repeat_reg;
        pos_next    = pos_reg;
        gather_next = gather_reg;
        tok_push    = 1'b0;
        tok.kind    = TOK_PIXEL;
        tok.value   = gather_new;
        tok.slot    = item.palette_slot;
        tok.run     = run_c;
        tok.last    = rem_small && (run_c == rem[7:0]);

        if (accept)
        begin
            unique case (cmd_t'(item.command))
                CMD_START:
                begin
                    done_next   = '0;
                    left_next   = '0;
                    repeat_next = 1'b0;
                    pos_next    = '0;
                    gather_next = '0;
                end
                CMD_PALETTE:
                begin
                    tok_push  = 1'b1;
                    tok.kind  = TOK_PALETTE;
                    tok.value = item.palette_word;
                end
                CMD_DATA:
                begin
                    if (!image_done)
                    begin
                        if (cfg.compressed_mode && (left_reg == 8'd0))
                        begin
                            repeat_next = (item.data_byte & HDR_REPEAT_BIT) != 8'd0;
                            left_next   = (item.data_byte & HDR_COUNT_MASK) + 8'd1;
                            pos_next    = '0;
                            gather_next = '0;
                        end
                        else if (!last_byte)
                        begin
                            pos_next    = pos_reg + POS_W'(1);
                            gather_next = gather_new;
                        end
                        else
                        begin
                            tok_push    = 1'b1;
                            pos_next    = '0;
                            gather_next = '0;
                            done_next   = done_reg + 32'(run_c);
                            if (cfg.compressed_mode)
                                left_next = repeat_reg ? 8'd0 : (left_reg - 8'd1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

### hdl/tgarle_tokq.sv
// ---------------------------------------------------------------------------
// tgarle_tokq
// Short request queue between the parser and the palette stage.
// ---------------------------------------------------------------------------
module tgarle_tokq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tgarle_pkg::tok_t  tok_in,
    output logic              full,
    input  logic              pop,
    output tgarle_pkg::tok_t  tok_out,
    output logic              empty
);
    import tgarle_pkg::*;

    tok_t               mem [TOKQ_DEPTH];
    logic [TOKQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [TOKQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [TOKQ_AW:0]   cnt_reg,    cnt_next;

    assign full    = (cnt_reg == (TOKQ_AW+1)'(TOKQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign tok_out = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + TOKQ_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + TOKQ_AW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + (TOKQ_AW+1)'(push) - (TOKQ_AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= tok_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### hdl/tgarle_back.sv
// ---------------------------------------------------------------------------
// tgarle_back
// Palette memory, index check, colour masking and result queue.
// ---------------------------------------------------------------------------
module tgarle_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tgarle_pkg::cfg_t    cfg,
    input  logic                tok_empty,
    input  tgarle_pkg::tok_t    tok,
    output logic                tok_pop,
    output tgarle_pkg::result_t result,
    output logic                empty,
    input  logic                pop
);
    import tgarle_pkg::*;

    logic [31:0] palette [PALETTE_DEPTH];

    logic        s1_valid_reg;
    logic        s1_mapped_reg;
    logic        s1_bad_reg;
    logic [31:0] s1_raw_reg;
    logic [7:0]  s1_run_reg;
    logic        s1_last_reg;
    logic [31:0] rd_data_reg;

    result_t            out_mem [OUT_DEPTH];
    logic [OUT_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [OUT_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [OUT_AW:0]    cnt_reg,    cnt_next;

    logic [23:0] idx;
    logic [8:0]  limit;
    logic        bad;
    logic        out_pop;
    logic [31:0] mask;
    result_t     s2_result;

    assign out_pop = pop && !empty;
    assign tok_pop = !tok_empty &&
                     ((cnt_reg + (OUT_AW+1)'(s1_valid_reg)) < (OUT_AW+1)'(OUT_DEPTH));

    always_comb
    begin
        idx   = tok.value[23:0] & INDEX_MASK[23:0];
        limit = (cfg.palette_length > 9'(PALETTE_DEPTH)) ? 9'(PALETTE_DEPTH)
                                                         : cfg.palette_length;
        bad   = (idx[23:9] != 15'd0) || (idx[8:0] >= limit);
    end

    always_ff @(posedge clk)
    begin
        if (tok_pop && (tok.kind == TOK_PALETTE))
            palette[tok.slot[PAL_AW-1:0]] <= tok.value;
        if (tok_pop && (tok.kind == TOK_PIXEL))
            rd_data_reg <= palette[idx[PAL_AW-1:0]];
        s1_mapped_reg <= cfg.color_mapped_mode;
        s1_bad_reg    <= bad;
        s1_raw_reg    <= tok.value;
        s1_run_reg    <= tok.run;
        s1_last_reg   <= tok.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= tok_pop && (tok.kind == TOK_PIXEL);
    end

    always_comb
    begin
        unique case (cfg.output_pixel_bytes)
            3'd0, 3'd1: mask = 32'h0000_00FF;
            3'd2:       mask = 32'h0000_FFFF;
            3'd3:       mask = 32'h00FF_FFFF;
            default:    mask = 32'hFFFF_FFFF;
        endcase

        s2_result.run_length    = s1_run_reg;
        s2_result.last_of_image = s1_last_reg;
        s2_result.status        = s1_mapped_reg && s1_bad_reg;
        if (!s1_mapped_reg)
            s2_result.pixel_value = s1_raw_reg;
        else if (s1_bad_reg)
            s2_result.pixel_value = 32'd0;
        else
            s2_result.pixel_value = rd_data_reg & mask;
    end

    assign empty  = (cnt_reg == '0);
    assign result = out_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = s1_valid_reg ? wr_ptr_reg + OUT_AW'(1) : wr_ptr_reg;
        rd_ptr_next = out_pop ? rd_ptr_reg + OUT_AW'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + (OUT_AW+1)'(s1_valid_reg) - (OUT_AW+1)'(out_pop);
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            out_mem[wr_ptr_reg] <= s2_result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### hdl/tgarle_checker.sv
// ---------------------------------------------------------------------------
// tgarle_checker
// Port-level checks on the decoder's result side, bound to the top level.
// ---------------------------------------------------------------------------
`include "tga_rle_pixel_decoder_core_assert.svh"

module tgarle_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                pop,
    input logic                empty,
    input tgarle_pkg::result_t result
);
    import tgarle_pkg::*;

    `TGARLE_ASSERT(a_run_range, !empty |-> (result.run_length != 8'd0 && result.run_length <= 8'd128), "run length out of range")
    `TGARLE_ASSERT(a_bad_is_zero, (!empty && result.status) |-> (result.pixel_value == 32'd0), "bad index with nonzero pixel")
    `TGARLE_ASSERT_ALWAYS(a_empty_in_reset, !rst_n |-> empty, "result shown during reset")
    `TGARLE_ASSERT(a_held_result, (!empty && !pop) |=> (!empty && $stable(result)), "waiting result changed")

endmodule

bind tga_rle_pixel_decoder_core tgarle_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .pop    (pop),
    .empty  (empty),
    .result (result)
);

### tb/tga_rle_checker.sv
// ----------------------------------------------------------------------------
// Run-length pixel decoder checker
// Watches the register port and both queue interfaces of the decoder. Keeps its
// own copy of registers, packet state and palette, works out the run that
// each accepted byte completes, and compares every popped run field by field
// with the oldest predicted one.
// ----------------------------------------------------------------------------
module tga_rle_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                full,
    input  tgarle_pkg::item_t   item,
    input  logic                pop,
    input  logic                empty,
    input  tgarle_pkg::result_t result,
    input  logic                wr_en,
    input  logic [2:0]          wr_index,
    input  logic [31:0]         wr_data,
    output int                  errors,
    output int                  pending,
    output int                  runs_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import tgarle_pkg::*;

    logic [2:0]  in_bytes;
    logic [2:0]  out_bytes;
    logic [31:0] image_px;
    logic        compressed;
    logic        mapped;
    logic [8:0]  pal_len;

    logic [31:0] px_done;
    logic [7:0]  pkt_left;
    logic        pkt_repeat;
    logic [2:0]  byte_pos;
    logic [31:0] gather;
    logic [31:0] palette_mem [PALETTE_DEPTH];

    result_t     predicted_runs [$];
    result_t     want;

    task automatic clear_stream();
        px_done    = '0;
        pkt_left   = '0;
        pkt_repeat = 1'b0;
        byte_pos   = '0;
        gather     = '0;
    endtask

    function automatic logic [31:0] pixel_colour(input logic [31:0] raw, output logic bad);
        logic [31:0] idx;
        int          limit;
        int          n;
        bad = 1'b0;
        if (!mapped)
            return raw;
        idx   = raw & INDEX_MASK;
        limit = (pal_len > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(pal_len);
        if (idx >= limit)
        begin
            bad = 1'b1;
            return '0;
        end
        n = (out_bytes == 3'd0) ? 1 : int'(out_bytes);
        if (n >= 4)
            return palette_mem[idx[PAL_AW-1:0]];
        return palette_mem[idx[PAL_AW-1:0]] & ((32'd1 << (8 * n)) - 32'd1);
    endfunction

    task automatic decode_request(input item_t it);
        int          n_in;
        logic [31:0] remaining;
        logic [31:0] run;
        logic        bad;
        result_t     r;
        case (it.command)
            CMD_START:
                clear_stream();
            CMD_PALETTE:
                palette_mem[it.palette_slot] = it.palette_word;
            CMD_DATA:
            begin
                if (px_done >= image_px)
                    return;
                if (compressed && pkt_left == 8'd0)
                begin
                    pkt_repeat = (it.data_byte & HDR_REPEAT_BIT) != 8'd0;
                    pkt_left   = (it.data_byte & HDR_COUNT_MASK) + 8'd1;
                    byte_pos   = '0;
                    gather     = '0;
                    return;
                end
                n_in = (in_bytes == 3'd0) ? 1 :
                       (in_bytes > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : int'(in_bytes);
                if (byte_pos < 3'd4)
                    gather = gather | (32'(it.data_byte) << (8 * byte_pos));
                if (int'(byte_pos) + 1 < n_in)
                begin
                    byte_pos = byte_pos + 3'd1;
                    return;
                end
                remaining = image_px - px_done;
                run = 32'd1;
                if (compressed)
                begin
                    if (pkt_repeat)
                    begin
                        run      = 32'(pkt_left);
                        pkt_left = '0;
                    end
                    else
                        pkt_left = pkt_left - 8'd1;
                end
                if (run > remaining)
                    run = remaining;
                r.pixel_value   = pixel_colour(gather, bad);
                r.status        = bad;
                px_done         = px_done + run;
                r.run_length    = run[7:0];
                r.last_of_image = (px_done == image_px);
                byte_pos        = '0;
                gather          = '0;
                predicted_runs.push_back(r);
            end
            default:
                ;
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_bytes   = 3'd1;
            out_bytes  = 3'd1;
            image_px   = 32'd1;
            compressed = 1'b0;
            mapped     = 1'b0;
            pal_len    = '0;
            clear_stream();
            predicted_runs.delete();
            errors    = 0;
            runs_seen = 0;
            pending   = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                runs_seen++;
                if (predicted_runs.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: run mismatch, expected none, actual %h", $time, result);
                end
                else
                begin
                    want = predicted_runs.pop_front();
                    compare_field("pixel_value", want.pixel_value, result.pixel_value);
                    compare_field("run_length", 32'(want.run_length), 32'(result.run_length));
                    compare_field("last_of_image", 32'(want.last_of_image),
                                  32'(result.last_of_image));
                    compare_field("status", 32'(want.status), 32'(result.status));
                end
            end
            if (wr_en)
            begin
                case (wr_index)
                    REG_IN_BYTES:     in_bytes   = wr_data[2:0];
                    REG_OUT_BYTES:    out_bytes  = wr_data[2:0];
                    REG_IMAGE_PIXELS: image_px   = wr_data;
                    REG_COMPRESSED:   compressed = wr_data[0];
                    REG_COLOR_MAPPED: mapped     = wr_data[0];
                    REG_PAL_LENGTH:   pal_len    = wr_data[8:0];
                    default:          ;
                endcase
            end
            if (push && !full)
                decode_request(item);
            pending = predicted_runs.size();
        end
    end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// Run-length pixel decoder testbench
// Drives directed corner cases and then random images through the decoder:
// raw and packet streams, palette lookups, run clamps and broken streams,
// with random stalls on both queues. The checker predicts and compares runs.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tgarle_pkg::*;

    localparam logic [1:0] CMD_UNUSED      = 2'd3;
    localparam int         IDLE_PCT        = 12;
    localparam int         SETTLE_CYCLES   = 8;
    localparam int         DRAIN_CYCLES    = 20;
    localparam int         WATCHDOG_LIMIT  = 2000;
    localparam int         RANDOM_REQUESTS = 1650;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    item_t       item;
    logic        pop;
    logic        empty;
    result_t     result;
    logic        wr_en;
    logic [2:0]  wr_index;
    logic [31:0] wr_data;

    int          errors;
    int          pending;
    int          runs_seen;
    int          requests;
    int          images;
    int          idle_cycles;
    bit          calm;
    bit          pal_written [PALETTE_DEPTH];

    tga_rle_pixel_decoder_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .pop      (pop),
        .empty    (empty),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    tga_rle_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .pop       (pop),
        .empty     (empty),
        .result    (result),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .errors    (errors),
        .pending   (pending),
        .runs_seen (runs_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            pop <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || wr_en || (push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send(input item_t it, input bit counted);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
        if (counted)
            requests++;
    endtask

    function automatic item_t noisy_item(input logic [1:0] cmd);
        item_t it;
        it.command      = cmd;
        it.data_byte    = 8'($urandom);
        it.palette_slot = 8'($urandom);
        it.palette_word = $urandom;
        return it;
    endfunction

    task automatic put_byte(input logic [7:0] b, input bit counted = 1'b1);
        item_t it;
        it = noisy_item(CMD_DATA);
        it.data_byte = b;
        send(it, counted);
    endtask

    task automatic put_start();
        send(noisy_item(CMD_START), 1'b1);
    endtask

    task automatic put_palette(input logic [7:0] slot, input logic [31:0] word);
        item_t it;
        it = noisy_item(CMD_PALETTE);
        it.palette_slot = slot;
        it.palette_word = word;
        pal_written[slot] = 1'b1;
        send(it, 1'b1);
    endtask

    // drain every predicted run, then let in-flight requests clear
    task automatic settle();
        push <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= v;
        @(negedge clk);
    endtask

    task automatic configure(input logic [31:0] ib, input logic [31:0] ob,
                             input logic [31:0] px, input logic [31:0] comp,
                             input logic [31:0] cm, input logic [31:0] pl);
        settle();
        write_reg(REG_IN_BYTES, ib);
        write_reg(REG_OUT_BYTES, ob);
        write_reg(REG_IMAGE_PIXELS, px);
        write_reg(REG_COMPRESSED, comp);
        write_reg(REG_COLOR_MAPPED, cm);
        write_reg(REG_PAL_LENGTH, pl);
        wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic put_pixel(input int nb, input bit cm, input int limit);
        logic [31:0] raw;
        if (cm && limit > 0 && $urandom_range(99) < 85)
            raw = {8'($urandom), 24'($urandom_range(0, limit - 1))};
        else
            raw = $urandom;
        for (int k = 0; k < nb; k++)
            put_byte(raw[8 * k +: 8]);
    endtask

    task automatic run_image(input logic [31:0] ib_w, input logic [31:0] ob_w,
                             input logic [31:0] px, input logic [31:0] comp_w,
                             input logic [31:0] cm_w, input logic [31:0] pl_w,
                             input int budget);
        int          nb;
        int          limit;
        int          count;
        int          r;
        int          sent;
        longint      done;
        bit          comp;
        bit          cm;
        logic [7:0]  hdr;
        configure(ib_w, ob_w, px, comp_w, cm_w, pl_w);
        put_start();
        comp  = comp_w[0];
        cm    = cm_w[0];
        nb    = (ib_w[2:0] == 3'd0) ? 1 :
                (ib_w[2:0] > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : int'(ib_w[2:0]);
        limit = (pl_w[8:0] > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(pl_w[8:0]);
        if (cm)
            for (int s = 0; s < limit; s++)
                if (!pal_written[s])
                    put_palette(8'(s), $urandom);
        done = 0;
        sent = 0;
        while (done < longint'(px) && sent < budget)
        begin
            r = $urandom_range(99);
            if (r < 3)
                send(noisy_item(CMD_UNUSED), 1'b0);
            else if (r < 5)
                put_palette(8'($urandom), $urandom);
            else if (r < 6)
            begin
                put_start();
                done = 0;
            end
            else if (r < 7)
            begin
                repeat ($urandom_range(1, nb)) put_byte(8'($urandom));
                put_start();
                done = 0;
            end
            else if (r < 8)
                break;
            if (comp)
            begin
                r = $urandom_range(99);
                if (r < 50)
                    count = $urandom_range(0, 7);
                else if (r < 90)
                    count = $urandom_range(0, 127);
                else
                    count = 127;
                hdr = {1'($urandom), 7'(count)};
                put_byte(hdr);
                sent++;
                if (hdr[7])
                begin
                    put_pixel(nb, cm, limit);
                    done += count + 1;
                    sent += nb;
                end
                else
                    for (int p = 0; p <= count && done < longint'(px); p++)
                    begin
                        put_pixel(nb, cm, limit);
                        done++;
                        sent += nb;
                    end
            end
            else
            begin
                put_pixel(nb, cm, limit);
                done++;
                sent += nb;
            end
        end
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom), 1'b0);
        images++;
    endtask

    initial
    begin
        int          r;
        int          base;
        logic [31:0] ib_w;
        logic [31:0] ob_w;
        logic [31:0] px;
        logic [31:0] pl_w;
        int          budget;

        rst_n    = 1'b0;
        push     = 1'b0;
        item     = '0;
        wr_en    = 1'b0;
        wr_index = '0;
        wr_data  = '0;
        calm     = 1'b0;
        requests = 0;
        images   = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset registers: one byte per pixel, one pixel, then ignored bytes
        put_start();
        put_byte(8'hFF);
        put_byte(8'h00);
        send(noisy_item(CMD_UNUSED), 1'b0);

        // widest pixel, longest repeat, huge image
        configure(4, 4, 32'hFFFF_FFFF, 1, 0, 0);
        put_start();
        put_byte(8'hFF);
        repeat (4) put_byte(8'hFF);

        // repeat run clamped to remaining pixels, zero byte count taken as one
        configure(0, 7, 3, 1, 0, 0);
        put_start();
        put_byte(8'h85);
        put_byte(8'h5A);
        put_byte(8'h11);

        // raw packet past the image end
        configure(2, 1, 2, 1, 0, 0);
        put_start();
        put_byte(8'h03);
        repeat (5) put_byte(8'($urandom));

        // palette hit at the top slot, then index past the palette depth
        configure(3, 2, 2, 0, 1, 300);
        put_start();
        put_palette(8'hFF, 32'hA5C3_5A3C);
        put_byte(8'hFF);
        put_byte(8'h00);
        put_byte(8'h00);
        put_byte(8'h00);
        put_byte(8'h01);
        put_byte(8'h00);

        // empty image
        configure(1, 1, 0, 0, 0, 0);
        put_start();
        put_byte(8'h42);

        base = requests;
        while (requests - base < RANDOM_REQUESTS)
        begin
            calm = (requests - base >= 700) && (requests - base < 1000);
            ib_w = ($urandom_range(99) < 15) ? $urandom_range(0, 7) : $urandom_range(1, 4);
            ob_w = $urandom_range(0, 7);
            r = $urandom_range(99);
            if (r < 10)
                pl_w = 0;
            else if (r < 20)
                pl_w = PALETTE_DEPTH;
            else if (r < 30)
                pl_w = $urandom_range(257, 511);
            else if (r < 40)
                pl_w = 1;
            else
                pl_w = $urandom_range(2, 255);
            if ($urandom_range(3) == 0)
            begin
                ib_w |= $urandom & ~32'h7;
                ob_w |= $urandom & ~32'h7;
                pl_w |= $urandom & ~32'h1FF;
            end
            budget = 400;
            r = $urandom_range(99);
            if (r < 5)
                px = 0;
            else if (r < 10)
            begin
                px = ($urandom_range(1) == 0) ? 32'hFFFF_FFFF : $urandom;
                budget = $urandom_range(20, 80);
            end
            else
                px = $urandom_range(1, 48);
            run_image(ib_w, ob_w, px, ($urandom_range(99) < 65) ? 32'd1 : 32'd0,
                      ($urandom_range(99) < 40) ? 32'd1 : 32'd0, pl_w, budget);
        end
        calm = 1'b0;

        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Ran %0d images with %0d requests; %0d runs compared with prediction.",
                 images, requests, runs_seen);
        $display("Covered raw and packet streams, palette lookups, clamps and restarts.");
        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
